/* hdl/wis_pkg.sv */
`default_nettype none

package wis_pkg;

   localparam int CMD_BITS    = 2;
   localparam int WEIGHT_IN   = 16;
   localparam int FRAC_BITS   = 32;
   localparam int SUM_BITS    = 24;
   localparam int INDEX_BITS  = 8;
   localparam int STATUS_BITS = 2;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_PICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   // which result the datapath forms on the finishing cycle
   typedef enum logic [2:0] {
      RES_NONE,
      RES_CLEARED,
      RES_LOADED,
      RES_FULL,
      RES_EMPTY,
      RES_PICKED
   } res_type;

   typedef struct packed {
      logic    capture;
      logic    clear;
      logic    load;
      logic    mul;
      logic    search;
      logic    finish;
      res_type res;
      logic    publish;
   } wis_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    pick_empty;
      logic    search_done;
   } wis_sts_type;

endpackage

`default_nettype wire

/* hdl/wis_req_if.sv */
`default_nettype none

interface wis_req_if;
   import wis_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_BITS-1:0]  cmd;
   logic [WEIGHT_IN-1:0] weight;
   logic [FRAC_BITS-1:0] rand_fraction;

   modport source (output valid, cmd, weight, rand_fraction, input ready);
   modport sink   (input valid, cmd, weight, rand_fraction, output ready);
endinterface

`default_nettype wire

/* hdl/wis_rsp_if.sv */
`default_nettype none

interface wis_rsp_if;
   import wis_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [INDEX_BITS-1:0]  index;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, index, status, input ready);
   modport sink   (input valid, index, status, output ready);
endinterface

`default_nettype wire

/* hdl/wis_ram.sv */
`default_nettype none

module wis_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

`default_nettype wire

/* hdl/wis_ctrl.sv */
`default_nettype none

module wis_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   input  wire wis_pkg::wis_sts_type sts,
   output wis_pkg::wis_cmd_type      cmd
);
   import wis_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SEARCH, S_HOLD} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.res      = RES_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (sts.cmd)
               CMD_CLEAR: begin
                  cmd.clear  = 1'b1;
                  cmd.finish = 1'b1;
                  cmd.res    = RES_CLEARED;
                  state_in   = S_HOLD;
               end
               CMD_LOAD: begin
                  cmd.finish = 1'b1;
                  state_in   = S_HOLD;
                  if (sts.full) begin
                     cmd.res = RES_FULL;
                  end else begin
                     cmd.load = 1'b1;
                     cmd.res  = RES_LOADED;
                  end
               end
               CMD_PICK: begin
                  if (sts.pick_empty) begin
                     cmd.finish = 1'b1;
                     cmd.res    = RES_EMPTY;
                     state_in   = S_HOLD;
                  end else begin
                     cmd.mul  = 1'b1;
                     state_in = S_SEARCH;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
                  cmd.res    = RES_NONE;
                  state_in   = S_HOLD;
               end
            endcase
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (sts.search_done) begin
               cmd.finish = 1'b1;
               cmd.res    = RES_PICKED;
               state_in   = S_HOLD;
            end
         end
         S_HOLD: begin
            if (slot_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

`default_nettype wire

/* hdl/wis_dpath.sv */
`default_nettype none

module wis_dpath #(
   parameter int MAX_ENTRIES = 256,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire wis_pkg::wis_cmd_type                  cmd,
   input  wire logic [wis_pkg::CMD_BITS-1:0]          req_cmd,
   input  wire logic [wis_pkg::WEIGHT_IN-1:0]         req_weight,
   input  wire logic [wis_pkg::FRAC_BITS-1:0]         req_rand_fraction,
   output wis_pkg::wis_sts_type                       sts,
   output logic      [wis_pkg::INDEX_BITS-1:0]        rsp_index,
   output logic      [wis_pkg::STATUS_BITS-1:0]       rsp_status
);
   import wis_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int PW = FRAC_BITS + SUM_BITS;
   localparam logic [63:0] WMASK_FULL = (64'd1 << WEIGHT_BITS) - 64'd1;
   localparam logic [WEIGHT_IN-1:0] WMASK = WMASK_FULL[WEIGHT_IN-1:0];

   // captured beat
   logic [CMD_BITS-1:0]  cmd_ff;
   logic [WEIGHT_IN-1:0] weight_ff;
   logic [FRAC_BITS-1:0] frac_ff;

   logic [CW-1:0]       count_ff;
   logic [SUM_BITS-1:0] total_ff;
   logic [SUM_BITS-1:0] r_ff;
   logic [CW-1:0]       lo_ff, hi_ff, mid_ff;
   logic [CW-1:0]       lo_in, hi_in, mid_in;

   logic [INDEX_BITS-1:0]  pend_index_ff, rsp_index_ff;
   status_type             pend_status_ff, rsp_status_ff;

   logic [SUM_BITS:0]     sum_wide;
   logic [SUM_BITS-1:0]   sum_sat;
   logic [PW-1:0]         product;
   logic [SUM_BITS-1:0]   rd_data;
   logic [AW-1:0]         rd_addr;
   logic [CW-1:0]         half_count;
   logic                  above;
   logic [CW-1:0]         pick_cw;
   logic [CW+INDEX_BITS-1:0] pick_ext, load_ext;

   assign sum_wide = {1'b0, total_ff} + (SUM_BITS+1)'(weight_ff & WMASK);
   assign sum_sat  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
   assign product  = PW'(frac_ff) * PW'(total_ff);

   assign half_count = count_ff >> 1;

   // one halving step per cycle; the next probe address comes from the updated bounds
   assign above  = rd_data > r_ff;
   assign lo_in  = above ? lo_ff : mid_ff + CW'(1);
   assign hi_in  = above ? mid_ff : hi_ff;
   assign mid_in = lo_in + ((hi_in - lo_in) >> 1);

   assign rd_addr = cmd.mul ? half_count[AW-1:0] : mid_in[AW-1:0];

   assign pick_cw  = (lo_in >= count_ff) ? count_ff - CW'(1) : lo_in;
   assign pick_ext = {{INDEX_BITS{1'b0}}, pick_cw};
   assign load_ext = {{INDEX_BITS{1'b0}}, count_ff};

   assign sts.cmd         = cmd_type'(cmd_ff);
   assign sts.full        = (count_ff == CW'(MAX_ENTRIES));
   assign sts.pick_empty  = (count_ff == '0) || (total_ff == '0);
   assign sts.search_done = (lo_in >= hi_in);

   assign rsp_index  = rsp_index_ff;
   assign rsp_status = rsp_status_ff;

   wis_ram #(
      .WIDTH(SUM_BITS),
      .DEPTH(MAX_ENTRIES)
   ) u_sums (
      .clock  (clock),
      .wr_en  (cmd.load),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(sum_sat),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
         total_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= count_ff + CW'(1);
         total_ff <= sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_cmd;
         weight_ff <= req_weight;
         frac_ff   <= req_rand_fraction;
      end
      if (cmd.mul) begin
         r_ff   <= product[PW-1:FRAC_BITS];
         lo_ff  <= '0;
         hi_ff  <= count_ff;
         mid_ff <= half_count;
      end else if (cmd.search) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         mid_ff <= mid_in;
      end
      if (cmd.finish) begin
         case (cmd.res)
            RES_CLEARED: begin
               pend_index_ff  <= '0;
               pend_status_ff <= ST_CLEARED;
            end
            RES_LOADED: begin
               pend_index_ff  <= load_ext[INDEX_BITS-1:0];
               pend_status_ff <= ST_OK;
            end
            RES_FULL: begin
               pend_index_ff  <= '0;
               pend_status_ff <= ST_FULL;
            end
            RES_EMPTY: begin
               pend_index_ff  <= '0;
               pend_status_ff <= ST_EMPTY;
            end
            RES_PICKED: begin
               pend_index_ff  <= pick_ext[INDEX_BITS-1:0];
               pend_status_ff <= ST_OK;
            end
            default: begin
               pend_index_ff  <= '0;
               pend_status_ff <= ST_OK;
            end
         endcase
      end
      if (cmd.publish) begin
         rsp_index_ff  <= pend_index_ff;
         rsp_status_ff <= pend_status_ff;
      end
   end
endmodule

`default_nettype wire

/* hdl/weighted_index_sampler_unit.sv */
// Channel   Dir  Beat carries                        Handshake
// req_chan  in   cmd[1:0] weight[15:0] rand[31:0]    valid/ready
// rsp_chan  out  index[7:0] status[1:0]             valid/ready
//
// One beat in, one beat out. A clear, load or unused command passes from
// acceptance through the execute and hold states to the next acceptance; a
// pick runs its binary search in between, one halving step per probe, with
// the single read port of the sum table giving one probe per cycle.
// Reset is synchronous and empties the table; the sum store is not cleared.
// A waiting response does not block the next request; a finished result waits
// in a holding register until the response register is free.
`default_nettype none

module weighted_index_sampler_unit #(
   parameter int MAX_ENTRIES = 256,
   parameter int WEIGHT_BITS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   wis_req_if.sink   req_chan,
   wis_rsp_if.source rsp_chan
);
   import wis_pkg::*;

   wis_cmd_type cmd;
   wis_sts_type sts;

   wis_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .rsp_ready(rsp_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .sts      (sts),
      .cmd      (cmd)
   );

   wis_dpath #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_cmd          (req_chan.cmd),
      .req_weight       (req_chan.weight),
      .req_rand_fraction(req_chan.rand_fraction),
      .sts              (sts),
      .rsp_index        (rsp_chan.index),
      .rsp_status       (rsp_chan.status)
   );

   // one request at a time: after a beat is taken the port closes
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while previous one still in work");

   // every error or clear result carries index zero
   a_err_index: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status != ST_OK) |-> rsp_chan.index == '0)
      else $error("non-ok response with nonzero index");

   // a new response appears only as the block returns to accepting requests
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> req_chan.ready)
      else $error("response raised outside completion");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && req_chan.ready)
      else $error("outputs not idle after reset");
endmodule

`default_nettype wire
